/* src/slsc_pkg.sv */
// ============================================================================
// slsc_pkg
// Shared types and constants for the scan likelihood scoring block.
// ============================================================================
package slsc_pkg;

    // Default grid depth and scan length ceiling
    localparam int GRID_CELLS_DEF  = 65536;
    localparam int MAX_SCAN_POINTS = 1024;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int IDX_W       = 9;   // column / row index
    localparam int N_W         = 11;  // scan length, points seen
    localparam int SUM_W       = 27;  // half-scan sum
    localparam int COORD_W     = 36;  // world coordinate
    localparam int DIFF_W      = 37;  // coordinate minus origin
    localparam int Q_W         = 38;  // cell index before range check
    localparam int CELL_ADDR_W = 18;  // row * cols + col
    localparam int DIV_NUM_W   = 44;
    localparam int DIV_DEN_W   = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_INV_RES       = 3'd2,
        CFG_GRID_COLS     = 3'd3,
        CFG_GRID_ROWS     = 3'd4,
        CFG_SCAN_POINTS   = 3'd5,
        CFG_SCORE_MODE    = 3'd6,
        CFG_INLIER_THRESH = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_POSE  = 2'd1,
        OP_POINT = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_MEAN   = 2'd0,
        MODE_HALF   = 2'd1,
        MODE_INLIER = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_SUM,
        S_AXM,
        S_AXC,
        S_ADDR,
        S_RD,
        S_ACC,
        S_EMIT,
        S_M1A,
        S_M1B,
        S_M1C,
        S_DIV
    } t_state;

endpackage

/* src/scan_likelihood_score_top.sv */
// ============================================================================
// scan_likelihood_score_top
// Scores a pose against a likelihood grid held in on-chip RAM.
// ============================================================================
// Items are issued with start while busy is low. A write item stores a Q0.16
// cell and never raises busy. A pose item makes two passes of the shared axis
// indexer (a multiply stage and a range check per axis). A scan point runs
// rotation products, world sum, two axis passes, cell address, one grid RAM
// read, accumulate. The point that closes the scan, or a pose item when the
// scan length is zero, adds the final score: directly for an invalid pose or
// short scan, otherwise through the bit-serial 44-bit divider, which the
// half-scan mode first feeds from its multiply states. Each result is shown
// for exactly one cycle on o_result_valid; the receiver cannot stall it, so
// sample it then. Points beyond the scan length and unused opcodes are
// dropped without a result. Grid cells read before they are written return
// undefined values.
// ============================================================================
module scan_likelihood_score_top #(
    parameter int GRID_CELLS = slsc_pkg::GRID_CELLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_opcode,
    input  logic [15:0]                     i_cell_address,
    input  logic [15:0]                     i_cell_value,
    input  logic signed [31:0]              i_pose_x,
    input  logic signed [31:0]              i_pose_y,
    input  logic signed [15:0]              i_pose_cos,
    input  logic signed [15:0]              i_pose_sin,
    input  logic signed [31:0]              i_point_x,
    input  logic signed [31:0]              i_point_y,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [slsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slsc_pkg::CFG_W-1:0]      i_cfg_data,
    // result
    output logic                            o_result_valid,
    output logic [15:0]                     o_score,
    output logic                            o_pose_valid
);

    import slsc_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);

    // configuration registers
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [31:0]        r_inv_res;
    logic [IDX_W-1:0]   r_cols;
    logic [IDX_W-1:0]   r_rows;
    logic [N_W-1:0]     r_scan_pts;
    logic [1:0]         r_mode;
    logic [15:0]        r_thr;

    t_state r_state, n_state;

    // held pose and point
    logic signed [31:0] r_pose_x, r_pose_y, r_px, r_py;
    logic signed [15:0] r_cos, r_sin;
    logic               r_job_pose;
    logic               r_pose_ok;

    // point datapath
    logic signed [47:0]        r_m_cx, r_m_sy, r_m_sx, r_m_cy;
    logic signed [COORD_W-1:0] r_wx, r_wy;
    logic                      r_sel;
    logic                      r_neg;
    logic [36:0]               r_prod_hi;
    logic [31:0]               r_prod_lo_hi;
    logic                      r_okx;
    logic [IDX_W-1:0]          r_col, r_row;
    logic                      r_hit_axes;
    logic                      r_hit;
    logic [CELL_ADDR_W-1:0]    r_raddr;
    logic [SUM_W-1:0]          r_sum_a, r_sum_b;
    logic [N_W-1:0]            r_seen;

    // scoring
    logic [1:0]           r_fmode;
    logic [37:0]          r_p1, r_p2, r_t2;
    logic [38:0]          r_t1;
    logic [21:0]          r_t3;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_div_go;
    logic                 r_result_valid;
    logic [15:0]          r_score;
    logic                 r_pose_valid;

    // combinational
    logic                      w_accept;
    logic [N_W-1:0]            w_n, w_h, w_d2, w_d, w_seen_inc;
    logic signed [48:0]        w_dx, w_dy;
    logic signed [COORD_W-1:0] w_coord;
    logic signed [31:0]        w_origin;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [DIFF_W-1:0]         w_mag;
    logic [63:0]               w_plo;
    logic [Q_W-1:0]            w_q;
    logic [IDX_W-1:0]          w_limit;
    logic                      w_axis_ok;
    logic [CELL_ADDR_W-1:0]    w_addr;
    logic [31:0]               w_addr_ext, w_raddr_ext, w_waddr_ext;
    logic                      w_we;
    logic [15:0]               w_v;
    logic                      w_short;
    logic                      w_pick_a;
    logic [SUM_W-1:0]          w_x;
    logic [SUM_W:0]            w_ab;
    logic                      w_div_done;
    logic [DIV_NUM_W-1:0]      w_quot;
    logic [15:0]               w_final;

    assign w_accept = start && !busy;
    assign busy     = r_state != S_IDLE;

    // scan length saturates at the ceiling
    assign w_n = (r_scan_pts > N_W'(MAX_SCAN_POINTS)) ? N_W'(MAX_SCAN_POINTS)
                                                         : r_scan_pts;
    assign w_h        = w_n >> 1;
    assign w_d2       = w_n - w_h;
    assign w_seen_inc = r_seen + 1'b1;
    assign w_ab       = (SUM_W + 1)'(r_sum_a) + (SUM_W + 1)'(r_sum_b);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_inv_res  <= 32'd1310720;
            r_cols     <= IDX_W'(256);
            r_rows     <= IDX_W'(256);
            r_scan_pts <= '0;
            r_mode     <= MODE_MEAN;
            r_thr      <= 16'd19661;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:      r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y:      r_origin_y <= i_cfg_data;
                CFG_INV_RES:       r_inv_res  <= i_cfg_data;
                CFG_GRID_COLS:     r_cols     <= i_cfg_data[IDX_W-1:0];
                CFG_GRID_ROWS:     r_rows     <= i_cfg_data[IDX_W-1:0];
                CFG_SCAN_POINTS:   r_scan_pts <= i_cfg_data[N_W-1:0];
                CFG_SCORE_MODE:    r_mode     <= i_cfg_data[1:0];
                CFG_INLIER_THRESH: r_thr      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Grid memory: write items go straight in, reads are one per point
    // ------------------------------------------------------------------
    assign w_waddr_ext = 32'(i_cell_address);
    assign w_raddr_ext = 32'(r_raddr);
    assign w_we = w_accept && (i_opcode == OP_WRITE) && (w_waddr_ext < 32'(GRID_CELLS));

    slsc_ram #(
        .WIDTH (16),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr_ext[AW-1:0]),
        .i_wdata (i_cell_value),
        .i_raddr (w_raddr_ext[AW-1:0]),
        .o_rdata (w_v)
    );

    // ------------------------------------------------------------------
    // World coordinates: floor of the Q2.14 rotation, plus pose
    // ------------------------------------------------------------------
    assign w_dx = 49'(r_m_cx) - 49'(r_m_sy);
    assign w_dy = 49'(r_m_sx) + 49'(r_m_cy);

    // ------------------------------------------------------------------
    // Shared axis indexer: pass 0 handles x/cols, pass 1 y/rows.
    // Index = trunc(|diff| * inv_res / 2^32), negative side only at zero.
    // ------------------------------------------------------------------
    assign w_coord  = r_sel ? r_wy : r_wx;
    assign w_origin = r_sel ? r_origin_y : r_origin_x;
    assign w_diff   = DIFF_W'(w_coord) - DIFF_W'(w_origin);
    assign w_mag    = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    assign w_plo    = 64'(w_mag[31:0]) * 64'(r_inv_res);
    assign w_q      = Q_W'(r_prod_hi) + Q_W'(r_prod_lo_hi);
    assign w_limit  = r_sel ? r_rows : r_cols;
    assign w_axis_ok = !(r_neg && (w_q != '0)) && (w_q < Q_W'(w_limit));

    assign w_addr     = CELL_ADDR_W'(r_row) * CELL_ADDR_W'(r_cols) + CELL_ADDR_W'(r_col);
    assign w_addr_ext = 32'(w_addr);

    // ------------------------------------------------------------------
    // Scoring helpers
    // ------------------------------------------------------------------
    assign w_short  = (t_mode'(r_mode) == MODE_HALF) ? (w_n < N_W'(2)) : (w_n == '0);
    assign w_pick_a = r_p1 >= r_p2;
    assign w_x      = w_pick_a ? r_sum_a : r_sum_b;
    assign w_d      = w_pick_a ? w_h : w_d2;

    slsc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // inlier ratio saturates; any valid score of zero becomes 1 LSB
    always_comb begin
        if (w_quot == '0) begin
            w_final = 16'd1;
        end else if ((t_mode'(r_fmode) == MODE_INLIER) && (w_quot > DIV_NUM_W'(65535))) begin
            w_final = 16'hFFFF;
        end else begin
            w_final = w_quot[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_POSE:  n_state = S_AXM;
                        OP_POINT: n_state = (r_seen < w_n) ? S_ROT : S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ROT: n_state = S_SUM;
            S_SUM: n_state = S_AXM;
            S_AXM: n_state = S_AXC;
            S_AXC: begin
                if (!r_sel) begin
                    n_state = S_AXM;
                end else if (r_job_pose) begin
                    n_state = (w_n == '0) ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_RD;
            S_RD:   n_state = S_ACC;
            S_ACC:  n_state = (w_seen_inc == w_n) ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (!r_pose_ok || w_short) begin
                    n_state = S_IDLE;
                end else if (t_mode'(r_mode) == MODE_HALF) begin
                    n_state = S_M1A;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_M1A: n_state = S_M1B;
            S_M1B: n_state = S_M1C;
            S_M1C: n_state = S_DIV;
            S_DIV: n_state = w_div_done ? S_IDLE : S_DIV;
            default: n_state = S_IDLE;
        endcase
    end

    // control state of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x       <= '0;
            r_pose_y       <= '0;
            r_cos          <= '0;
            r_sin          <= '0;
            r_pose_ok      <= 1'b0;
            r_sum_a        <= '0;
            r_sum_b        <= '0;
            r_seen         <= '0;
            r_sel          <= 1'b0;
            r_job_pose     <= 1'b0;
            r_div_go       <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_div_go       <= 1'b0;
            r_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_opcode == OP_POSE)) begin
                        r_pose_x   <= i_pose_x;
                        r_pose_y   <= i_pose_y;
                        r_cos      <= i_pose_cos;
                        r_sin      <= i_pose_sin;
                        r_sum_a    <= '0;
                        r_sum_b    <= '0;
                        r_seen     <= '0;
                        r_sel      <= 1'b0;
                        r_job_pose <= 1'b1;
                    end else if (w_accept && (i_opcode == OP_POINT)) begin
                        r_sel      <= 1'b0;
                        r_job_pose <= 1'b0;
                    end
                end
                S_AXC: begin
                    r_sel <= 1'b1;
                    if (r_sel && r_job_pose) begin
                        r_pose_ok <= r_okx && w_axis_ok;
                    end
                end
                S_ACC: begin
                    // accumulate under the live mode
                    if (r_hit) begin
                        if (t_mode'(r_mode) == MODE_INLIER) begin
                            if (w_v >= r_thr) begin
                                r_sum_a <= r_sum_a + 1'b1;
                            end
                        end else if (w_v != '0) begin
                            if (r_seen < w_h) begin
                                r_sum_a <= r_sum_a + SUM_W'(w_v);
                            end else begin
                                r_sum_b <= r_sum_b + SUM_W'(w_v);
                            end
                        end
                    end
                    r_seen <= w_seen_inc;
                end
                S_EMIT: begin
                    if (!r_pose_ok || w_short) begin
                        r_result_valid <= 1'b1;
                    end else if (t_mode'(r_mode) != MODE_HALF) begin
                        r_div_go <= 1'b1;
                    end
                end
                S_M1C: r_div_go <= 1'b1;
                S_DIV: begin
                    if (w_div_done) begin
                        r_result_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_px <= i_point_x;
                    r_py <= i_point_y;
                    // a pose item indexes its own position
                    r_wx <= COORD_W'(i_pose_x);
                    r_wy <= COORD_W'(i_pose_y);
                end
            end
            S_ROT: begin
                r_m_cx <= r_cos * r_px;
                r_m_sy <= r_sin * r_py;
                r_m_sx <= r_sin * r_px;
                r_m_cy <= r_cos * r_py;
            end
            S_SUM: begin
                r_wx <= COORD_W'($signed(w_dx[48:14])) + COORD_W'(r_pose_x);
                r_wy <= COORD_W'($signed(w_dy[48:14])) + COORD_W'(r_pose_y);
            end
            S_AXM: begin
                r_neg        <= w_diff[DIFF_W-1];
                r_prod_lo_hi <= w_plo[63:32];
                r_prod_hi    <= 37'(w_mag[DIFF_W-1:32]) * 37'(r_inv_res);
            end
            S_AXC: begin
                if (!r_sel) begin
                    r_okx <= w_axis_ok;
                    r_col <= w_q[IDX_W-1:0];
                end else begin
                    r_hit_axes <= r_okx && w_axis_ok;
                    r_row      <= w_q[IDX_W-1:0];
                end
            end
            S_ADDR: begin
                r_raddr <= w_addr;
                r_hit   <= r_hit_axes && (w_addr_ext < 32'(GRID_CELLS));
            end
            S_EMIT: begin
                r_fmode      <= r_mode;
                r_score      <= '0;
                r_pose_valid <= 1'b0;
                r_den        <= DIV_DEN_W'(w_n);
                if (t_mode'(r_mode) == MODE_INLIER) begin
                    r_num <= DIV_NUM_W'(w_ab) << 16;
                end else begin
                    r_num <= DIV_NUM_W'(w_ab);
                end
            end
            S_M1A: begin
                r_p1 <= 38'(r_sum_a) * 38'(w_d2);
                r_p2 <= 38'(r_sum_b) * 38'(w_h);
            end
            S_M1B: begin
                r_t1 <= 39'(w_ab) * 39'(w_d);
                r_t2 <= 38'(w_x) * 38'(w_n);
                r_t3 <= 22'(w_n) * 22'(w_d);
            end
            S_M1C: begin
                // 7*t1 + 3*t2 over 10*t3
                r_num <= (DIV_NUM_W'(r_t1) << 3) - DIV_NUM_W'(r_t1)
                       + (DIV_NUM_W'(r_t2) << 1) + DIV_NUM_W'(r_t2);
                r_den <= (DIV_DEN_W'(r_t3) << 3) + (DIV_DEN_W'(r_t3) << 1);
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_score      <= w_final;
                    r_pose_valid <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_result_valid = r_result_valid;
    assign o_score        = r_score;
    assign o_pose_valid   = r_pose_valid;

endmodule

/* src/slsc_ram.sv */
// ============================================================================
// slsc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module slsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/slsc_div.sv */
// ============================================================================
// slsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module slsc_div #(
    parameter int NUM_W = slsc_pkg::DIV_NUM_W,
    parameter int DEN_W = slsc_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_quot[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    // control: step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift numerator out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
